// ===== rtl/cbfd_pkg.sv =====
// cbfd_pkg: shared types and constants of the byte-offset decoder
// no dependencies; imported by every other file of the block except cbfd_ifs and cbfd_checker

package cbfd_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned COUNT_W = 24;

  // escape codes of the byte-offset scheme
  localparam logic [7:0]  ESC_BYTE = 8'h80;
  localparam logic [15:0] ESC_WORD = 16'h8000;

  // register reset and default queue depth
  localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET   = 24'd1;
  localparam int unsigned        QUEUE_DEPTH_DEFAULT = 2;

  // parse phase of the front end
  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_W16_LO = 3'd1,
    PH_W16_HI = 3'd2,
    PH_W32_B0 = 3'd3,
    PH_W32_B1 = 3'd4,
    PH_W32_B2 = 3'd5,
    PH_W32_B3 = 3'd6
  } phase_t;

  // one decoded delta travelling from front to back
  typedef struct packed {
    logic [PIXEL_W-1:0] delta;
    logic               clear;
    logic               last;
  } delta_t;

  // queue handshake as seen by either end
  typedef struct packed {
    logic   valid;
    delta_t item;
  } delta_req_t;

endpackage

// ===== rtl/cbfd_ifs.sv =====
// cbfd_ifs: stream interfaces of the byte-offset decoder
// no dependencies

interface cbfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface cbfd_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_value;
  logic               last_pixel;

  modport source (output valid, output pixel_value, output last_pixel, input ready);
  modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface

// ===== rtl/cbfd_front.sv =====
// cbfd_front: byte parser, pixel counter and pixel_count register
// depends on cbfd_pkg and cbfd_ifs; pushes one delta item per pixel

module cbfd_front (
  input  logic                    clk,
  input  logic                    rst,
  cbfd_byte_if.sink               stream,
  input  logic                    cfg_we,
  input  logic [cbfd_pkg::COUNT_W-1:0] cfg_data,
  output cbfd_pkg::delta_req_t    push,
  input  logic                    push_ready
);
  import cbfd_pkg::*;

  phase_t             phase, phase_next;
  logic [23:0]        gather, gather_next;
  logic [COUNT_W-1:0] pixels_done, pixels_done_next;
  logic [COUNT_W-1:0] pixel_count;
  logic               clear_pending;

  phase_t             phase_eff;
  logic [23:0]        gather_eff;
  logic [COUNT_W-1:0] done_eff;
  logic [COUNT_W-1:0] done_inc;
  logic               complete;
  logic               emit;
  logic [PIXEL_W-1:0] delta;
  logic [15:0]        word16;
  logic               accept;

  assign stream.ready = push_ready;
  assign accept       = stream.valid && push_ready;

  // image start clears the parse state before the byte is decoded
  assign phase_eff  = stream.image_start ? PH_FIRST : phase;
  assign gather_eff = stream.image_start ? 24'd0 : gather;
  assign done_eff   = stream.image_start ? '0 : pixels_done;
  assign done_inc   = done_eff + 1'b1;
  assign complete   = (done_eff >= pixel_count);
  assign word16     = {stream.data_byte, gather_eff[7:0]};

  // classify the byte against the current phase
  always_comb begin
    emit        = 1'b0;
    delta       = '0;
    phase_next  = phase_eff;
    gather_next = gather_eff;
    case (phase_eff)
      PH_W16_LO: begin
        gather_next = {16'd0, stream.data_byte};
        phase_next  = PH_W16_HI;
      end
      PH_W16_HI: begin
        if (word16 != ESC_WORD) begin
          emit  = 1'b1;
          delta = {{16{word16[15]}}, word16};
        end else begin
          gather_next = 24'd0;
          phase_next  = PH_W32_B0;
        end
      end
      PH_W32_B0: begin
        gather_next = {gather_eff[23:8], stream.data_byte};
        phase_next  = PH_W32_B1;
      end
      PH_W32_B1: begin
        gather_next = {gather_eff[23:16], stream.data_byte, gather_eff[7:0]};
        phase_next  = PH_W32_B2;
      end
      PH_W32_B2: begin
        gather_next = {stream.data_byte, gather_eff[15:0]};
        phase_next  = PH_W32_B3;
      end
      PH_W32_B3: begin
        emit  = 1'b1;
        delta = {stream.data_byte, gather_eff};
      end
      default: begin
        if (stream.data_byte != ESC_BYTE) begin
          emit  = 1'b1;
          delta = {{24{stream.data_byte[7]}}, stream.data_byte};
        end else begin
          gather_next = 24'd0;
          phase_next  = PH_W16_LO;
        end
      end
    endcase
    if (complete) begin
      emit        = 1'b0;
      phase_next  = phase_eff;
      gather_next = gather_eff;
    end
    if (emit) begin
      phase_next  = PH_FIRST;
      gather_next = 24'd0;
    end
    pixels_done_next = emit ? done_inc : done_eff;
  end

  // delta item toward the queue
  assign push.valid      = accept && emit;
  assign push.item.delta = delta;
  assign push.item.clear = stream.image_start || clear_pending;
  assign push.item.last  = (done_inc == pixel_count);

  // parse state and pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      gather        <= 24'd0;
      pixels_done   <= '0;
      clear_pending <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      gather      <= gather_next;
      pixels_done <= pixels_done_next;
      if (emit) begin
        clear_pending <= 1'b0;
      end else if (stream.image_start) begin
        clear_pending <= 1'b1;
      end
    end
  end

  // pixel_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= PIXEL_COUNT_RESET;
    end else if (cfg_we) begin
      pixel_count <= cfg_data;
    end
  end

endmodule

// ===== rtl/cbfd_queue.sv =====
// cbfd_queue: short delta queue between parser and accumulator
// depends on cbfd_pkg; register file of DEPTH entries

module cbfd_queue #(
  parameter int unsigned DEPTH = cbfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cbfd_pkg::delta_req_t push,
  output logic                 push_ready,
  output cbfd_pkg::delta_req_t pop,
  input  logic                 pop_ready
);
  import cbfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  delta_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop.valid  = (count != '0);
  assign pop.item   = slots[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cbfd_back.sv =====
// cbfd_back: running-sum accumulator and pixel output register
// depends on cbfd_pkg and cbfd_ifs

module cbfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cbfd_pkg::delta_req_t pop,
  output logic                 pop_ready,
  cbfd_pixel_if.source         pixels
);
  import cbfd_pkg::*;

  logic [PIXEL_W-1:0] running_sum;
  logic               out_valid;
  logic               out_last;
  logic               take;

  // load a new item whenever the output register is free or being taken
  assign pop_ready = !out_valid || pixels.ready;
  assign take      = pop.valid && pop_ready;

  assign pixels.valid       = out_valid;
  assign pixels.pixel_value = running_sum;
  assign pixels.last_pixel  = out_last;

  // sum wraps modulo 2^32; image start restarts it at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
      out_last    <= 1'b0;
    end else begin
      if (take) begin
        running_sum <= (pop.item.clear ? '0 : running_sum) + pop.item.delta;
        out_last    <= pop.item.last;
      end
      if (pop_ready) begin
        out_valid <= pop.valid;
      end
    end
  end

endmodule

// ===== rtl/cbf_byte_offset_decoder.sv =====
// cbf_byte_offset_decoder: top level of the byte-offset pixel decoder
// depends on cbfd_pkg, cbfd_ifs, cbfd_front, cbfd_queue, cbfd_back
//
//   port      dir   handshake       payload
//   stream    in    valid/ready     data_byte[7:0], image_start
//   pixels    out   valid/ready     pixel_value[31:0] signed, last_pixel
//   cfg       in    cfg_we          cfg_data[23:0] = pixel_count
//
// one byte per cycle in while ready is high, at most one pixel per cycle out
// a completed delta passes through a queue entry and then the output register on its way to pixel valid
// the parser feeds a QUEUE_DEPTH-entry queue; ready drops only when the
// queue is full behind a stalled pixel output
// reset empties the queue, clears the sum and sets pixel_count to 1

module cbf_byte_offset_decoder #(
  parameter int unsigned QUEUE_DEPTH = cbfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  cbfd_byte_if.sink                    stream,
  cbfd_pixel_if.source                 pixels,
  input  logic                         cfg_we,
  input  logic [cbfd_pkg::COUNT_W-1:0] cfg_data
);
  import cbfd_pkg::*;

  delta_req_t push, pop;
  logic       push_ready, pop_ready;

  // parser front end
  cbfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_ready (push_ready)
  );

  // decoupling queue
  cbfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  // accumulator back end
  cbfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_ready (pop_ready),
    .pixels    (pixels)
  );

endmodule

// ===== rtl/cbfd_checker.sv =====
// cbfd_checker: port-level assertions for the byte-offset decoder
// depends on cbf_byte_offset_decoder; attached by the bind at the end

module cbfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_last
);

  // no pixel is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel valid right after reset");

  // queue is empty after reset, so a byte can be taken
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("byte input not ready after reset");

  // a full queue implies the output register holds a pixel
  a_full_backed: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output is empty");

  // a stalled pixel keeps its value and flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled pixel changed");

endmodule

bind cbf_byte_offset_decoder cbfd_checker u_cbfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (stream.ready),
  .out_valid (pixels.valid),
  .out_ready (pixels.ready),
  .out_value (pixels.pixel_value),
  .out_last  (pixels.last_pixel)
);

// ===== dv/cbfd_pixel_checker.sv =====
// cbfd_pixel_checker: predicts decoded pixels from the accepted byte stream and
// compares them with the pixel output of the byte-offset decoder
// depends on cbfd_pkg and the stream interfaces in cbfd_ifs

module cbfd_pixel_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cbfd_pkg::COUNT_W-1:0] cfg_data,
  cbfd_byte_if                         stream,
  cbfd_pixel_if                        pixels,
  output int                           failures,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cbfd_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               last;
  } pixel_exp_t;

  typedef logic bool_t;

  pixel_exp_t           expected_pixels[$];
  phase_t               phase;
  logic [PIXEL_W-1:0]   gathered;
  logic [PIXEL_W-1:0]   sum;
  logic [COUNT_W-1:0]   done_count;
  logic [COUNT_W-1:0]   pix_count;

  // add one delta to the running sum and queue the pixel it makes
  task automatic add_delta(input logic [PIXEL_W-1:0] delta);
    sum        = sum + delta;
    done_count = done_count + 1'b1;
    phase      = PH_FIRST;
    gathered   = '0;
    expected_pixels.push_back('{value: sum, last: (done_count == pix_count)});
  endtask

  // advance the byte-offset parser by one accepted item
  task automatic decode_byte(input logic [7:0] b, input logic start);
    if (start) begin
      sum        = '0;
      done_count = '0;
      phase      = PH_FIRST;
      gathered   = '0;
    end
    // a complete image swallows bytes until the next start
    if (done_count >= pix_count) return;
    case (phase)
      PH_W16_LO: begin
        gathered = {24'h0, b};
        phase    = PH_W16_HI;
      end
      PH_W16_HI: begin
        gathered[15:8] = b;
        if (gathered[15:0] != ESC_WORD) begin
          add_delta({{16{gathered[15]}}, gathered[15:0]});
        end else begin
          gathered = '0;
          phase    = PH_W32_B0;
        end
      end
      PH_W32_B0: begin
        gathered[7:0] = b;
        phase         = PH_W32_B1;
      end
      PH_W32_B1: begin
        gathered[15:8] = b;
        phase          = PH_W32_B2;
      end
      PH_W32_B2: begin
        gathered[23:16] = b;
        phase           = PH_W32_B3;
      end
      PH_W32_B3: begin
        gathered[31:24] = b;
        add_delta(gathered);
      end
      default: begin
        if (b != ESC_BYTE) begin
          add_delta({{24{b[7]}}, b});
        end else begin
          gathered = '0;
          phase    = PH_W16_LO;
        end
      end
    endcase
  endtask

  // compare one accepted pixel with the oldest expectation
  task automatic check_pixel(input logic [PIXEL_W-1:0] value, input logic last);
    pixel_exp_t exp_pix;
    bool_t      bad;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel value %h last %b", $time, value, last);
      failures++;
      return;
    end
    exp_pix = expected_pixels.pop_front();
    bad     = 1'b0;
    if (value !== exp_pix.value) begin
      $display("%0t: pixel_value expected %h actual %h", $time, exp_pix.value, value);
      bad = 1'b1;
    end
    if (last !== exp_pix.last) begin
      $display("%0t: last_pixel expected %b actual %b", $time, exp_pix.last, last);
      bad = 1'b1;
    end
    if (bad) failures++;
  endtask

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_FIRST;
      gathered   = '0;
      sum        = '0;
      done_count = '0;
      pix_count  = PIXEL_COUNT_RESET;
      failures   = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) pix_count = cfg_data;
      if (stream.valid && stream.ready) decode_byte(stream.data_byte, stream.image_start);
      if (pixels.valid && pixels.ready) check_pixel(pixels.pixel_value, pixels.last_pixel);
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== dv/cbf_byte_offset_decoder_test.sv =====
// cbf_byte_offset_decoder_test: drives compressed byte streams and pixel-count
// settings into the decoder and gives the verdict
// depends on cbfd_pkg, cbfd_ifs, cbf_byte_offset_decoder and cbfd_pixel_checker

module cbf_byte_offset_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbfd_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_BYTES  = 190;

  // delta encodings of the byte-offset scheme
  typedef enum int {
    DELTA_BYTE = 0,
    DELTA_WORD = 1,
    DELTA_LONG = 2
  } delta_form_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_data;
  int                 failures;
  int                 pending;
  int                 bytes_sent;
  int                 quiet_cycles;
  bit                 idle_on;
  logic [COUNT_W-1:0] count_now;

  cbfd_byte_if  stream ();
  cbfd_pixel_if pixels ();

  cbf_byte_offset_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .stream   (stream),
    .pixels   (pixels),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  cbfd_pixel_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stream   (stream),
    .pixels   (pixels),
    .failures (failures),
    .pending  (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pause length: mostly none or short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // send one item and hold it until accepted
  task automatic put_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pick_pause();
    @(negedge clk);
    if (gap > 0) begin
      stream.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stream.valid       <= 1'b1;
    stream.data_byte   <= b;
    stream.image_start <= start;
    @(posedge clk);
    while (!stream.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // encode one delta in the given form
  task automatic put_delta(input logic [31:0] d, input delta_form_t form, input logic start);
    case (form)
      DELTA_BYTE: put_byte(d[7:0], start);
      DELTA_WORD: begin
        put_byte(ESC_BYTE, start);
        put_byte(d[7:0], 1'b0);
        put_byte(d[15:8], 1'b0);
      end
      default: begin
        put_byte(ESC_BYTE, start);
        put_byte(ESC_WORD[7:0], 1'b0);
        put_byte(ESC_WORD[15:8], 1'b0);
        put_byte(d[7:0], 1'b0);
        put_byte(d[15:8], 1'b0);
        put_byte(d[23:16], 1'b0);
        put_byte(d[31:24], 1'b0);
      end
    endcase
  endtask

  // random delta, extremes favored for the wide forms
  task automatic random_delta(output logic [31:0] d, output delta_form_t form);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      form = DELTA_BYTE;
      d    = $urandom_range(0, 255);
      if (d[7:0] == ESC_BYTE) d = 32'h7f;
    end else if (r < 80) begin
      form = DELTA_WORD;
      case ($urandom_range(0, 9))
        0: d = 32'h7fff;
        1: d = 32'h8001;
        2: d = 32'hffff;
        3: d = 32'h0000;
        default: d = $urandom_range(0, 16'hffff);
      endcase
      if (d[15:0] == ESC_WORD) d = 32'h8001;
    end else begin
      form = DELTA_LONG;
      case ($urandom_range(0, 9))
        0: d = 32'h8000_0000;
        1: d = 32'h7fff_ffff;
        2: d = 32'hffff_ffff;
        3: d = $urandom_range(0, 255);
        default: d = $urandom;
      endcase
    end
  endtask

  // drop valid, let the decoder drain, then write the pixel count
  task automatic set_pixel_count(input logic [COUNT_W-1:0] v);
    @(negedge clk);
    stream.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    count_now = v;
  endtask

  // one image of n pixels, trailing bytes sometimes
  task automatic put_image(input int n);
    logic [31:0] d;
    delta_form_t form;
    for (int i = 0; i < n; i++) begin
      random_delta(d, form);
      put_delta(d, form, i == 0);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // a few pixels, then a delta cut off by the next image start
  task automatic put_broken_image();
    logic [31:0] d;
    delta_form_t form;
    logic [7:0]  enc[7];
    int          n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      random_delta(d, form);
      put_delta(d, form, i == 0);
    end
    d   = $urandom;
    enc = '{ESC_BYTE, ESC_WORD[7:0], ESC_WORD[15:8], d[7:0], d[15:8], d[23:16], d[31:24]};
    for (int k = 0; k < $urandom_range(1, 6); k++) put_byte(enc[k], n == 0 && k == 0);
  endtask

  // random phase: mostly images (whole ones, now and then cut short, for counts up to 64), some broken ones and noise
  task automatic random_phase(input logic [COUNT_W-1:0] count);
    int target;
    int r;
    int n;
    set_pixel_count(count);
    idle_on = ($urandom_range(0, 3) != 0);
    target  = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      r = $urandom_range(0, 99);
      if (r < 78) begin
        n = (count_now <= 64) ? int'(count_now) : $urandom_range(1, 40);
        if (count_now <= 64 && $urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        put_image(n);
      end else if (r < 90) begin
        put_broken_image();
      end else begin
        repeat ($urandom_range(1, 8))
          put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // pixel output ready with random stalls
  initial begin
    int hold;
    hold = 0;
    pixels.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pixels.ready <= 1'b0;
        hold--;
      end else begin
        pixels.ready <= 1'b1;
        hold = pick_pause();
      end
    end
  end

  // watchdog on cycles with no item accepted on either channel
  always @(posedge clk) begin
    if (rst || (stream.valid && stream.ready) || (pixels.valid && pixels.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    stream.valid       = 1'b0;
    stream.data_byte   = '0;
    stream.image_start = 1'b0;
    bytes_sent         = 0;
    quiet_cycles       = 0;
    idle_on            = 1'b1;
    count_now          = PIXEL_COUNT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-pixel images at the reset count, byte extremes, ignored trailing item
    put_delta(32'h0, DELTA_BYTE, 1'b1);
    put_byte(8'h12, 1'b0);
    put_delta(32'h7f, DELTA_BYTE, 1'b1);
    put_delta(32'h81, DELTA_BYTE, 1'b1);
    put_delta(32'hff, DELTA_BYTE, 1'b1);

    // word and long escapes, sum wrap, then a delta cut off by a new image
    set_pixel_count(24'd12);
    put_delta(32'h7fff, DELTA_WORD, 1'b1);
    put_delta(32'h8001, DELTA_WORD, 1'b0);
    put_delta(32'hffff, DELTA_WORD, 1'b0);
    put_delta(32'h0000, DELTA_WORD, 1'b0);
    put_delta(32'h8000_0000, DELTA_LONG, 1'b0);
    put_delta(32'h7fff_ffff, DELTA_LONG, 1'b0);
    put_delta(32'hffff_ffff, DELTA_LONG, 1'b0);
    put_delta(32'h0000_0001, DELTA_LONG, 1'b0);
    put_byte(ESC_BYTE, 1'b0);
    put_byte(ESC_WORD[7:0], 1'b0);
    put_delta(32'h3, DELTA_BYTE, 1'b1);

    // random phases over several pixel counts, extremes included
    random_phase(24'd1);
    random_phase(24'd2);
    random_phase(24'd3);
    random_phase(24'd7);
    random_phase(24'd16);
    random_phase(24'd64);
    random_phase(COUNT_W'($urandom_range(1, 40)));
    random_phase(COUNT_W'($urandom_range(65, 24'hfffffe)));
    random_phase(24'hffffff);
    random_phase(24'd5);

    // drain and give the verdict
    @(negedge clk);
    stream.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
